### hw/rtl/w104_pkg.sv
// Shared types and constants for the 104-bit passphrase key derivation block.
// Holds the MD5 round tables, chaining init values, FSM encodings and the
// request struct. No dependencies.
package w104_pkg;

    localparam int BLOCK_BYTES = 64;
    localparam int BLOCK_WORDS = 16;
    localparam int MD5_ROUNDS  = 64;

    localparam logic [31:0] SINE_TAB [MD5_ROUNDS] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    localparam logic [4:0] ROT_TAB [16] = '{
        5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
        5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
    };

    localparam logic [31:0] CHAIN_INIT [4] = '{
        32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
    };

    // padding block for a 64-byte message: 0x80 marker, bit length 512
    localparam logic [3:0]  PAD_MARK_IDX = 4'd0;
    localparam logic [31:0] PAD_MARK_W   = 32'h0000_0080;
    localparam logic [3:0]  PAD_LEN_IDX  = 4'd14;
    localparam logic [31:0] PAD_LEN_W    = 32'h0000_0200;

    typedef enum logic [2:0] {
        S_LOAD,
        S_FILL,
        S_H1,
        S_W1,
        S_H2,
        S_W2,
        S_EMIT
    } t_seq_state;

    typedef enum logic [2:0] {
        M_IDLE,
        M_FETCH,
        M_SUM,
        M_ROT,
        M_ADD
    } t_md5_state;

    typedef struct packed {
        logic start;
        logic pad;      // 1: hash the constant padding block
    } t_md5_req;

endpackage

### hw/rtl/w104_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module w104_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/w104_md5.sv
// MD5 compression engine: one shared round datapath stepped 64 times, each
// round passing through fetch, sum and rotate states, then the chaining add.
// Depends on w104_pkg; message words come from the block RAM in the top level.
module w104_md5 (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  w104_pkg::t_md5_req i_req,
    output logic [3:0]        o_raddr,
    input  logic [31:0]       i_rdata,
    output logic              o_done,
    output logic [127:0]      o_digest
);
    import w104_pkg::*;

    t_md5_state  r_state, n_state;
    logic [31:0] r_chain [4];
    logic [31:0] r_a, r_b, r_c, r_d;
    logic [5:0]  r_round;
    logic        r_pad;
    logic [3:0]  r_g;
    logic [31:0] r_ak;
    logic [31:0] r_t;
    logic        r_done;

    logic [1:0]  w_grp;
    logic [3:0]  w_r4;
    logic [3:0]  w_g;
    logic [31:0] w_f;
    logic [31:0] w_msg;
    logic [4:0]  w_s;
    logic [63:0] w_rot2;
    logic [31:0] w_rot;

    assign w_grp = r_round[5:4];
    assign w_r4  = r_round[3:0];
    assign w_s   = ROT_TAB[{w_grp, r_round[1:0]}];

    always_comb begin
        case (w_grp)
            2'd0: begin
                w_g = w_r4;
                w_f = (r_b & r_c) | (~r_b & r_d);
            end
            2'd1: begin
                w_g = (w_r4 << 2) + w_r4 + 4'd1;
                w_f = (r_b & r_d) | (r_c & ~r_d);
            end
            2'd2: begin
                w_g = (w_r4 << 1) + w_r4 + 4'd5;
                w_f = r_b ^ r_c ^ r_d;
            end
            default: begin
                w_g = (w_r4 << 3) - w_r4;
                w_f = r_c ^ (r_b | ~r_d);
            end
        endcase
    end

    always_comb begin
        if (!r_pad) begin
            w_msg = i_rdata;
        end else if (r_g == PAD_MARK_IDX) begin
            w_msg = PAD_MARK_W;
        end else if (r_g == PAD_LEN_IDX) begin
            w_msg = PAD_LEN_W;
        end else begin
            w_msg = '0;
        end
    end

    assign w_rot2 = {r_t, r_t} << w_s;
    assign w_rot  = w_rot2[63:32];

    assign o_raddr  = w_g;
    assign o_done   = r_done;
    assign o_digest = {r_chain[3], r_chain[2], r_chain[1], r_chain[0]};

    always_comb begin
        n_state = r_state;
        case (r_state)
            M_IDLE:  if (i_req.start) n_state = M_FETCH;
            M_FETCH: n_state = M_SUM;
            M_SUM:   n_state = M_ROT;
            M_ROT:   n_state = (r_round == 6'(MD5_ROUNDS - 1)) ? M_ADD : M_FETCH;
            M_ADD:   n_state = M_IDLE;
            default: n_state = M_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= M_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done  <= 1'b0;
            r_round <= '0;
            r_pad   <= 1'b0;
            for (int i = 0; i < 4; i++) begin
                r_chain[i] <= CHAIN_INIT[i];
            end
        end else begin
            r_done <= 1'b0;
            case (r_state)
                M_IDLE: begin
                    if (i_req.start) begin
                        r_round <= '0;
                        r_pad   <= i_req.pad;
                        if (!i_req.pad) begin
                            for (int i = 0; i < 4; i++) begin
                                r_chain[i] <= CHAIN_INIT[i];
                            end
                        end
                    end
                end
                M_ROT: begin
                    r_round <= r_round + 6'd1;
                end
                M_ADD: begin
                    r_chain[0] <= r_chain[0] + r_a;
                    r_chain[1] <= r_chain[1] + r_b;
                    r_chain[2] <= r_chain[2] + r_c;
                    r_chain[3] <= r_chain[3] + r_d;
                    r_done     <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    // working words and round temporaries
    always_ff @(posedge i_clk) begin
        case (r_state)
            M_IDLE: begin
                if (i_req.start) begin
                    if (!i_req.pad) begin
                        r_a <= CHAIN_INIT[0];
                        r_b <= CHAIN_INIT[1];
                        r_c <= CHAIN_INIT[2];
                        r_d <= CHAIN_INIT[3];
                    end else begin
                        r_a <= r_chain[0];
                        r_b <= r_chain[1];
                        r_c <= r_chain[2];
                        r_d <= r_chain[3];
                    end
                end
            end
            M_FETCH: begin
                r_g  <= w_g;
                r_ak <= r_a + SINE_TAB[r_round];
            end
            M_SUM: begin
                r_t <= w_f + r_ak + w_msg;
            end
            M_ROT: begin
                r_a <= r_d;
                r_d <= r_c;
                r_c <= r_b;
                r_b <= r_b + w_rot;
            end
            default: ;
        endcase
    end

endmodule

### hw/rtl/wep_104_md5_passphrase_key.sv
// 104-bit WEP key from a passphrase: MD5 over the passphrase repeated to 64 bytes.
// Top level; depends on w104_pkg, w104_ram and w104_md5.
//
// Input stream: one nonzero passphrase character per transfer in tdata[7:0],
// tlast on the final character. The first 64 characters are kept, later ones
// and zero characters are dropped. Non-final characters are taken one per cycle.
// After the final character the block drops tready for the whole derivation:
// it expands the phrase into the block RAM (one byte per cycle through the
// phrase RAM read port), then runs two MD5 compressions of 64 rounds each on
// the shared round datapath.
// Output stream: KEY_BYTES transfers, tdata[7:0] digest byte, tdata[11:8] its
// index, tlast on the final byte. A stalled receiver simply holds the current
// byte; nothing is lost. After the last key byte the block takes a new phrase.
// Reset (synchronous, active low) empties the phrase and idles the engine; the
// RAM contents are not cleared.
module wep_104_md5_passphrase_key #(
    parameter int KEY_BYTES = 13
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] pass_byte
    input  logic        i_s_axis_tlast,   // pass_last
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,   // [7:0] key_byte, [11:8] key_index, rest zero
    output logic        o_m_axis_tlast    // key_last
);
    import w104_pkg::*;

    t_seq_state  r_state, n_state;
    logic [6:0]  r_len;
    logic [5:0]  r_j;
    logic [6:0]  r_fcnt;
    logic        r_pend;
    logic [5:0]  r_pos;
    logic [23:0] r_acc;
    logic [3:0]  r_kidx;

    logic        w_in_xfer;
    logic        w_out_xfer;
    logic        w_key_last;
    logic        w_ph_we;
    logic [7:0]  w_ph_rdata;
    logic [7:0]  w_fbyte;
    logic        w_blk_we;
    logic [31:0] w_blk_wdata;
    logic [3:0]  w_blk_raddr;
    logic [31:0] w_blk_rdata;
    t_md5_req    w_req;
    logic        w_md5_done;
    logic [127:0] w_digest;

    assign w_in_xfer  = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_xfer = o_m_axis_tvalid && i_m_axis_tready;
    assign w_key_last = (r_kidx == 4'(KEY_BYTES - 1));
    assign w_ph_we    = w_in_xfer && (i_s_axis_tdata != 8'd0) && (r_len < 7'(BLOCK_BYTES));

    // empty phrase hashes an all-zero block
    assign w_fbyte     = (r_len == 7'd0) ? 8'd0 : w_ph_rdata;
    assign w_blk_we    = r_pend && (r_pos[1:0] == 2'd3);
    assign w_blk_wdata = {w_fbyte, r_acc};

    w104_ram #(.WIDTH(8), .DEPTH(BLOCK_BYTES)) u_phrase (
        .i_clk   (i_clk),
        .i_we    (w_ph_we),
        .i_waddr (r_len[5:0]),
        .i_wdata (i_s_axis_tdata),
        .i_raddr (r_j),
        .o_rdata (w_ph_rdata)
    );

    w104_ram #(.WIDTH(32), .DEPTH(BLOCK_WORDS)) u_block (
        .i_clk   (i_clk),
        .i_we    (w_blk_we),
        .i_waddr (r_pos[5:2]),
        .i_wdata (w_blk_wdata),
        .i_raddr (w_blk_raddr),
        .o_rdata (w_blk_rdata)
    );

    w104_md5 u_md5 (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (w_req),
        .o_raddr  (w_blk_raddr),
        .i_rdata  (w_blk_rdata),
        .o_done   (w_md5_done),
        .o_digest (w_digest)
    );

    always_comb begin
        n_state         = r_state;
        o_s_axis_tready = 1'b0;
        o_m_axis_tvalid = 1'b0;
        w_req.start     = 1'b0;
        w_req.pad       = 1'b0;
        case (r_state)
            S_LOAD: begin
                o_s_axis_tready = 1'b1;
                if (w_in_xfer && i_s_axis_tlast) n_state = S_FILL;
            end
            S_FILL: begin
                if (r_fcnt == 7'(BLOCK_BYTES) && !r_pend) n_state = S_H1;
            end
            S_H1: begin
                w_req.start = 1'b1;
                n_state     = S_W1;
            end
            S_W1: begin
                if (w_md5_done) n_state = S_H2;
            end
            S_H2: begin
                w_req.start = 1'b1;
                w_req.pad   = 1'b1;
                n_state     = S_W2;
            end
            S_W2: begin
                if (w_md5_done) n_state = S_EMIT;
            end
            S_EMIT: begin
                o_m_axis_tvalid = 1'b1;
                if (w_out_xfer && w_key_last) n_state = S_LOAD;
            end
            default: n_state = S_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len  <= '0;
            r_j    <= '0;
            r_fcnt <= '0;
            r_pend <= 1'b0;
            r_kidx <= '0;
        end else begin
            r_pend <= 1'b0;
            case (r_state)
                S_LOAD: begin
                    if (w_ph_we) r_len <= r_len + 7'd1;
                    r_j    <= '0;
                    r_fcnt <= '0;
                end
                S_FILL: begin
                    // issue one phrase read per cycle, wrapping at the phrase length
                    if (r_fcnt != 7'(BLOCK_BYTES)) begin
                        r_fcnt <= r_fcnt + 7'd1;
                        r_pend <= 1'b1;
                        r_j    <= ({1'b0, r_j} + 7'd1 == r_len) ? 6'd0 : r_j + 6'd1;
                    end
                end
                S_W2: begin
                    r_kidx <= '0;
                end
                S_EMIT: begin
                    if (w_out_xfer) begin
                        r_kidx <= r_kidx + 4'd1;
                        if (w_key_last) r_len <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_FILL) begin
            r_pos <= r_fcnt[5:0];
        end
        if (r_pend) begin
            r_acc <= {w_fbyte, r_acc[23:8]};
        end
    end

    assign o_m_axis_tdata = {4'd0, r_kidx, w_digest[{r_kidx, 3'b000} +: 8]};
    assign o_m_axis_tlast = w_key_last;

endmodule

### hw/rtl/w104_chk.sv
// Port-level checker for the passphrase key derivation block, bound to the top.
// Depends on nothing but the top level's ports.
module w104_chk #(
    parameter int KEY_BYTES = 13
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_axis_tvalid,
    input logic        o_s_axis_tready,
    input logic [7:0]  i_s_axis_tdata,
    input logic        i_s_axis_tlast,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [15:0] o_m_axis_tdata,
    input logic        o_m_axis_tlast
);

    // stalled key byte holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("key byte changed under stall");

    // input is never taken while key bytes are pending
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_s_axis_tready && o_m_axis_tvalid))
        else $error("input ready while output pending");

    // final character starts derivation, input closes
    a_last_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready && i_s_axis_tlast |=> !o_s_axis_tready)
        else $error("input still open after final character");

    // key bytes come back to back until the final one
    a_key_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && i_m_axis_tready && !o_m_axis_tlast |=>
            o_m_axis_tvalid && o_m_axis_tdata[11:8] == $past(o_m_axis_tdata[11:8]) + 4'd1)
        else $error("key byte sequence broken");

    // final key byte carries the last index
    a_last_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tlast |-> o_m_axis_tdata[11:8] == 4'(KEY_BYTES - 1))
        else $error("tlast on wrong key index");

endmodule

bind wep_104_md5_passphrase_key w104_chk #(.KEY_BYTES(KEY_BYTES)) u_w104_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tdata  (i_s_axis_tdata),
    .i_s_axis_tlast  (i_s_axis_tlast),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tlast  (o_m_axis_tlast)
);

### test/wep_104_key_checker.sv
// Scoreboard for wep_104_md5_passphrase_key: watches both stream channels,
// derives the expected key bytes with its own MD5 and compares each transfer.
// No dependencies; instantiated by wep_104_md5_passphrase_key_tb.
module wep_104_key_checker #(
    parameter int KEY_LEN = 13
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [7:0]  i_s_tdata,    // [7:0] pass_byte
    input  logic        i_s_tlast,    // pass_last
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [15:0] i_m_tdata,    // [7:0] key_byte, [11:8] key_index
    input  logic        i_m_tlast,    // key_last
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PHRASE_MAX = 64;

    localparam logic [31:0] MD5_K [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    localparam int MD5_S [16] = '{
        7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21
    };

    localparam logic [127:0] MD5_IV = {
        32'h10325476, 32'h98badcfe, 32'hefcdab89, 32'h67452301
    };

    typedef struct packed {
        logic [7:0] key_byte;
        logic [3:0] key_index;
        logic       key_last;
    } t_key_rec;

    t_key_rec     key_q [$];
    t_key_rec     got, want;
    logic [7:0]   phrase [PHRASE_MAX];
    int           phrase_len;
    logic [511:0] msg_blk, pad_blk;
    logic [127:0] digest;
    int           fails;

    // word g of a block is bytes 4g..4g+3, little endian: blk[32*g +: 32]
    function automatic logic [127:0] md5_compress(input logic [127:0] chain,
                                                  input logic [511:0] blk);
        logic [31:0] a, b, c, d, f, t;
        int g, r, s;
        a = chain[31:0];
        b = chain[63:32];
        c = chain[95:64];
        d = chain[127:96];
        for (r = 0; r < 64; r++) begin
            case (r / 16)
                0: begin
                    f = (b & c) | (~b & d);
                    g = r;
                end
                1: begin
                    f = (b & d) | (c & ~d);
                    g = (5 * r + 1) % 16;
                end
                2: begin
                    f = b ^ c ^ d;
                    g = (3 * r + 5) % 16;
                end
                default: begin
                    f = c ^ (b | ~d);
                    g = (7 * r) % 16;
                end
            endcase
            f = f + a + MD5_K[r] + blk[32 * g +: 32];
            s = MD5_S[(r / 16) * 4 + r % 4];
            t = d;
            d = c;
            c = b;
            b = b + ((f << s) | (f >> (32 - s)));
            a = t;
        end
        return {d + chain[127:96], c + chain[95:64], b + chain[63:32], a + chain[31:0]};
    endfunction

    initial begin
        pad_blk = '0;
        pad_blk[7:0] = 8'h80;
        pad_blk[8 * 57 +: 8] = 8'h02;   // 512-bit message length
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            phrase_len = 0;
            key_q.delete();
        end else begin
            if (i_s_tvalid && i_s_tready) begin
                if (i_s_tdata != 8'd0 && phrase_len < PHRASE_MAX) begin
                    phrase[phrase_len] = i_s_tdata;
                    phrase_len++;
                end
                if (i_s_tlast) begin
                    // repeat the phrase to 64 bytes; empty phrase hashes zeros
                    for (int i = 0; i < PHRASE_MAX; i++)
                        msg_blk[8 * i +: 8] = (phrase_len == 0) ? 8'd0 : phrase[i % phrase_len];
                    digest = md5_compress(md5_compress(MD5_IV, msg_blk), pad_blk);
                    for (int i = 0; i < KEY_LEN; i++) begin
                        want.key_byte  = digest[8 * (i % 16) +: 8];
                        want.key_index = 4'(i);
                        want.key_last  = (i == KEY_LEN - 1);
                        key_q.push_back(want);
                    end
                    phrase_len = 0;
                end
            end
            if (i_m_tvalid && i_m_tready) begin
                got.key_byte  = i_m_tdata[7:0];
                got.key_index = i_m_tdata[11:8];
                got.key_last  = i_m_tlast;
                if (key_q.size() == 0) begin
                    if (fails < 10)
                        $display("%0t: key byte %02h idx %0d with nothing pending",
                                 $realtime, got.key_byte, got.key_index);
                    fails++;
                end else begin
                    want = key_q.pop_front();
                    if (got !== want) begin
                        if (fails < 10)
                            $display("%0t: key mismatch exp byte %02h idx %0d last %0b,",
                                     $realtime, want.key_byte, want.key_index,
                                     want.key_last,
                                     " got byte %02h idx %0d last %0b",
                                     got.key_byte, got.key_index, got.key_last);
                        fails++;
                    end
                end
            end
        end
        o_fail_count <= fails;
        o_pending    <= key_q.size();
    end

endmodule

### test/wep_104_md5_passphrase_key_tb.sv
// Top of the testbench for wep_104_md5_passphrase_key: clock, reset, phrase
// stimulus with bursty sender and stalling receiver, and the verdict.
// Depends on the block's RTL and wep_104_key_checker.
module wep_104_md5_passphrase_key_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int KEY_LEN    = 13;
    localparam int ITEM_GOAL  = 250;
    localparam int HOLD_CYC   = 1000;
    localparam int DRAIN_CYC  = 600;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_data;
    logic        s_last;
    logic        m_valid;
    logic        m_ready;
    logic [15:0] m_data;
    logic        m_last;
    int          fail_cnt;
    int          pend_cnt;

    logic        hold_req;
    int          burst_left;
    int          items_sent;
    int          phrase_pos;

    wep_104_md5_passphrase_key #(
        .KEY_BYTES(KEY_LEN)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(s_valid),
        .o_s_axis_tready(s_ready),
        .i_s_axis_tdata (s_data),
        .i_s_axis_tlast (s_last),
        .o_m_axis_tvalid(m_valid),
        .i_m_axis_tready(m_ready),
        .o_m_axis_tdata (m_data),
        .o_m_axis_tlast (m_last)
    );

    wep_104_key_checker #(
        .KEY_LEN(KEY_LEN)
    ) i_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (s_valid),
        .i_s_tready  (s_ready),
        .i_s_tdata   (s_data),
        .i_s_tlast   (s_last),
        .i_m_tvalid  (m_valid),
        .i_m_tready  (m_ready),
        .i_m_tdata   (m_data),
        .i_m_tlast   (m_last),
        .o_fail_count(fail_cnt),
        .o_pending   (pend_cnt)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // one character per transfer; sender runs in bursts with random gaps
    task automatic send_char(input logic [7:0] ch, input logic last);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                s_valid = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        s_valid = 1'b1;
        s_data  = ch;
        s_last  = last;
        do @(posedge i_clk); while (!s_ready);
        @(negedge i_clk);
        burst_left--;
        if (ch != 8'd0 && phrase_pos < 64)
            items_sent++;
        else if (last)
            items_sent++;
        phrase_pos = last ? 0 : phrase_pos + 1;
    endtask

    task automatic send_phrase(input int len, input int zero_odds);
        logic [7:0] ch;
        for (int k = 0; k < len; k++) begin
            ch = $urandom_range(1, 255);
            if (zero_odds > 0 && $urandom_range(1, zero_odds) == 1)
                ch = 8'd0;
            send_char(ch, k == len - 1);
        end
    endtask

    task automatic wait_drained();
        while (pend_cnt != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // receiver: stall pattern switches among four random modes, plus one long hold
    initial begin
        int rx_mode;
        int mode_left;
        mode_left = 0;
        rx_mode = 0;
        m_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                m_ready = 1'b0;
                repeat (HOLD_CYC - 1) @(negedge i_clk);
                hold_req = 1'b0;
            end else begin
                if (mode_left == 0) begin
                    rx_mode = $urandom_range(0, 3);
                    mode_left = $urandom_range(20, 120);
                end
                mode_left--;
                case (rx_mode)
                    0: m_ready = 1'b1;
                    1: m_ready = 1'($urandom_range(0, 1));
                    2: m_ready = ($urandom_range(0, 3) == 0);
                    default: m_ready = ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    initial begin
        int len;
        int pick;
        s_valid = 1'b0;
        s_data = 8'd0;
        s_last = 1'b0;
        hold_req = 1'b0;
        burst_left = 0;
        items_sent = 0;
        phrase_pos = 0;
        i_rst_n = 1'b0;
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;

        // empty phrase, one-character extremes, zero chars inside and on last
        send_char(8'h00, 1'b1);
        send_char(8'hff, 1'b1);
        send_char(8'h01, 1'b1);
        send_char(8'h41, 1'b0);
        send_char(8'h00, 1'b0);
        send_char(8'h42, 1'b0);
        send_char(8'h43, 1'b1);
        send_char(8'h7f, 1'b0);
        send_char(8'h80, 1'b0);
        send_char(8'h55, 1'b0);
        send_char(8'haa, 1'b1);
        send_char(8'h61, 1'b0);
        send_char(8'h62, 1'b0);
        send_char(8'h00, 1'b1);

        // sender pauses until the block has delivered everything
        s_valid = 1'b0;
        wait_drained();
        hold_req = 1'b1;

        // first a full 64-char phrase and an overlong one, then mostly short
        pick = 0;
        while (items_sent < ITEM_GOAL) begin
            if (pick == 0)
                len = 64;
            else if (pick == 1)
                len = 70;
            else begin
                case ($urandom_range(0, 19))
                    0: len = 0;
                    1: len = $urandom_range(60, 72);
                    2, 3: len = $urandom_range(13, 40);
                    default: len = $urandom_range(1, 12);
                endcase
            end
            pick++;
            if (len == 0)
                send_char(8'h00, 1'b1);
            else
                send_phrase(len, ($urandom_range(0, 4) == 0) ? 8 : 0);
        end
        s_valid = 1'b0;

        wait_drained();
        repeat (DRAIN_CYC) @(posedge i_clk);
        if (fail_cnt == 0 && pend_cnt == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
